>>> src/psev_pkg.sv
package psev_pkg;

   localparam int WORD_W = 32;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int LEVEL_W = 8;
   localparam int STACK_DEPTH_DEF = 128;

   // Divider: magnitude of a * 2^16 needs 48 bits, two quotient bits per cycle.
   localparam int DIV_DVD_W = 48;
   localparam int DIV_STEPS_PER_CYCLE = 2;
   localparam int DIV_CYCLES = DIV_DVD_W / DIV_STEPS_PER_CYCLE;
   localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB = 3'd2;
   localparam logic [OP_W-1:0] OP_MUL = 3'd3;
   localparam logic [OP_W-1:0] OP_DIV = 3'd4;
   localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

   localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic                load_req;
      logic                push;
      logic                read_below;
      logic                pop_answer;
      logic                refill_tos;
      logic                load_a;
      logic                mul_load;
      logic                div_start;
      logic                commit;
      logic                out_load;
      logic [STATUS_W-1:0] out_status;
      logic                out_answer;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            empty;
      logic            has_two;
      logic            full;
      logic            divisor_zero;
      logic            div_done;
      logic            out_free;
   } dpath_status_type;

endpackage

>>> src/psev_ram.sv
module psev_ram #(
   parameter int WIDTH = psev_pkg::WORD_W,
   parameter int DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/psev_div.sv
module psev_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [psev_pkg::WORD_W-1:0] dividend,
   input  logic [psev_pkg::WORD_W-1:0] divisor,
   output logic                        done,
   output logic [psev_pkg::WORD_W-1:0] quotient
);
   import psev_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    den_ff, den_in;
   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;

   logic [WORD_W-1:0]    dividend_mag;
   logic [WORD_W-1:0]    divisor_mag;
   logic [WORD_W-1:0]    rem_w;
   logic [DIV_DVD_W-1:0] dvd_w;
   logic [DIV_DVD_W-1:0] quo_w;
   logic [WORD_W:0]      shifted;

   assign dividend_mag = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
   assign divisor_mag = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;

   // Restoring division on magnitudes, a fixed number of quotient bits per cycle.
   always_comb begin
      rem_w = rem_ff;
      dvd_w = dvd_ff;
      quo_w = quo_ff;
      shifted = '0;
      for (int k = 0; k < DIV_STEPS_PER_CYCLE; k++) begin
         shifted = {rem_w, dvd_w[DIV_DVD_W-1]};
         dvd_w = {dvd_w[DIV_DVD_W-2:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_w = WORD_W'(shifted - {1'b0, den_ff});
            quo_w = {quo_w[DIV_DVD_W-2:0], 1'b1};
         end else begin
            rem_w = shifted[WORD_W-1:0];
            quo_w = {quo_w[DIV_DVD_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         cnt_in = DIV_CNT_W'(DIV_CYCLES - 1);
         rem_in = '0;
         den_in = divisor_mag;
         dvd_in = {dividend_mag, {(DIV_DVD_W-WORD_W){1'b0}}};
         quo_in = '0;
      end else if (busy_ff) begin
         rem_in = rem_w;
         dvd_in = dvd_w;
         quo_in = quo_w;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   // Apply the sign to the magnitude and saturate to the word range.
   always_comb begin
      if (neg_ff) begin
         if ((quo_ff[DIV_DVD_W-1:WORD_W] != '0) ||
             (quo_ff[WORD_W-1] && (quo_ff[WORD_W-2:0] != '0))) begin
            quotient = SAT_MIN;
         end else begin
            quotient = ~quo_ff[WORD_W-1:0] + 1'b1;
         end
      end else begin
         if (quo_ff[DIV_DVD_W-1:WORD_W-1] != '0) begin
            quotient = SAT_MAX;
         end else begin
            quotient = quo_ff[WORD_W-1:0];
         end
      end
   end

   assign done = done_ff;

endmodule

>>> src/psev_ctrl.sv
module psev_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  psev_pkg::dpath_status_type st,
   output psev_pkg::ctrl_cmd_type     cmd
);
   import psev_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_READ = 3'd2;
   localparam logic [2:0] S_EXEC = 3'd3;
   localparam logic [2:0] S_MULRND = 3'd4;
   localparam logic [2:0] S_DIVWAIT = 3'd5;
   localparam logic [2:0] S_REFILL = 3'd6;
   localparam logic [2:0] S_RESULT = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                answer_ff, answer_in;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      answer_in = answer_ff;
      cmd = '0;
      cmd.out_status = status_ff;
      cmd.out_answer = answer_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               status_in = ST_OK;
               answer_in = 1'b0;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESULT;
            case (st.op)
               OP_PUSH: begin
                  if (st.full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (!st.has_two) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     cmd.read_below = 1'b1;
                     state_in = S_READ;
                  end
               end
               OP_FINISH: begin
                  if (st.empty) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     cmd.pop_answer = 1'b1;
                     answer_in = 1'b1;
                     // The entry below becomes the new top and must be fetched.
                     if (st.has_two) begin
                        cmd.read_below = 1'b1;
                        state_in = S_REFILL;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            cmd.load_a = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESULT;
            case (st.op)
               OP_MUL: begin
                  cmd.mul_load = 1'b1;
                  state_in = S_MULRND;
               end
               OP_DIV: begin
                  if (st.divisor_zero) begin
                     status_in = ST_DIVZERO;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in = S_DIVWAIT;
                  end
               end
               default: begin
                  cmd.commit = 1'b1;
               end
            endcase
         end
         S_MULRND: begin
            cmd.commit = 1'b1;
            state_in = S_RESULT;
         end
         S_DIVWAIT: begin
            if (st.div_done) begin
               cmd.commit = 1'b1;
               state_in = S_RESULT;
            end
         end
         S_REFILL: begin
            cmd.refill_tos = 1'b1;
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_OK;
         answer_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         answer_ff <= answer_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

>>> src/psev_dpath.sv
module psev_dpath #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  psev_pkg::ctrl_cmd_type             cmd,
   output psev_pkg::dpath_status_type         st,
   input  logic [psev_pkg::OP_W-1:0]          req_operation,
   input  logic signed [psev_pkg::WORD_W-1:0] req_operand,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [psev_pkg::WORD_W-1:0] rsp_top_value,
   output logic [psev_pkg::STATUS_W-1:0]      rsp_status,
   output logic [psev_pkg::LEVEL_W-1:0]       rsp_stack_level,
   output logic                               rsp_answer_valid
);
   import psev_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   function automatic logic [WORD_W-1:0] sat_to_word(input logic [63:0] v);
      if (v[63:WORD_W-1] == {(64-WORD_W+1){v[63]}}) begin
         return v[WORD_W-1:0];
      end
      return v[63] ? SAT_MIN : SAT_MAX;
   endfunction

   logic [OP_W-1:0]   op_ff;
   logic [WORD_W-1:0] operand_ff;
   logic [WORD_W-1:0] a_ff;
   logic [WORD_W-1:0] tos_ff;
   logic [WORD_W-1:0] ans_ff;
   logic [63:0]       prod_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_top_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [LEVEL_W-1:0]  rsp_stack_level_ff;
   logic              rsp_answer_valid_ff;

   logic [CNT_W-1:0]  count_m2;
   logic [63:0]       a_ext;
   logic [63:0]       b_ext;
   logic [63:0]       prod_rounded;
   logic [WORD_W-1:0] add_res;
   logic [WORD_W-1:0] sub_res;
   logic [WORD_W-1:0] mul_res;
   logic [WORD_W-1:0] div_res;
   logic [WORD_W-1:0] alu_res;
   logic [WORD_W-1:0] shown;
   logic              div_done;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic [WORD_W-1:0] ram_rd_data;

   assign count_m2 = count_ff - CNT_W'(2);
   assign a_ext = {{(64-WORD_W){a_ff[WORD_W-1]}}, a_ff};
   assign b_ext = {{(64-WORD_W){tos_ff[WORD_W-1]}}, tos_ff};
   assign add_res = sat_to_word(a_ext + b_ext);
   assign sub_res = sat_to_word(a_ext - b_ext);
   // Round to nearest with ties upward: add half an LSB, then floor by the shift.
   assign prod_rounded = 64'($signed(prod_ff + 64'd32768) >>> 16);
   assign mul_res = sat_to_word(prod_rounded);

   always_comb begin
      case (op_ff)
         OP_ADD: alu_res = add_res;
         OP_SUB: alu_res = sub_res;
         OP_MUL: alu_res = mul_res;
         OP_DIV: alu_res = div_res;
         default: alu_res = '0;
      endcase
   end

   psev_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (a_ff),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (div_res)
   );

   // Entry i of the stack lives at address i; the top is also held in tos_ff.
   assign ram_wr_en = cmd.push | cmd.commit;
   assign ram_wr_addr = cmd.push ? count_ff[ADDR_W-1:0] : count_m2[ADDR_W-1:0];
   assign ram_wr_data = cmd.push ? operand_ff : alu_res;

   psev_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.read_below),
      .rd_addr (count_m2[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.push) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.commit || cmd.pop_answer) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_operation;
         operand_ff <= req_operand;
      end
      if (cmd.load_a) begin
         a_ff <= ram_rd_data;
      end
      if (cmd.mul_load) begin
         prod_ff <= 64'($signed(a_ff) * $signed(tos_ff));
      end
      if (cmd.pop_answer) begin
         ans_ff <= tos_ff;
      end
      if (cmd.push) begin
         tos_ff <= operand_ff;
      end else if (cmd.commit) begin
         tos_ff <= alu_res;
      end else if (cmd.refill_tos) begin
         tos_ff <= ram_rd_data;
      end
   end

   assign shown = cmd.out_answer ? ans_ff : ((count_ff == '0) ? '0 : tos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_top_value_ff <= shown;
         rsp_status_ff <= cmd.out_status;
         rsp_stack_level_ff <= LEVEL_W'(count_ff);
         rsp_answer_valid_ff <= cmd.out_answer;
      end
   end

   always_comb begin
      st.op = op_ff;
      st.empty = (count_ff == '0);
      st.has_two = (count_ff >= CNT_W'(2));
      st.full = (count_ff == CNT_W'(STACK_DEPTH));
      st.divisor_zero = (tos_ff == '0);
      st.div_done = div_done;
      st.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_top_value = rsp_top_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_stack_level = rsp_stack_level_ff;
   assign rsp_answer_valid = rsp_answer_valid_ff;

endmodule

>>> src/postfix_stack_evaluator_core.sv
// Postfix expression evaluator on a stack of signed Q16.16 values. Each request
// is one token (push, add, subtract, multiply, divide or finish) and gives exactly
// one response with the top of stack, a status code, the stack level and, on a
// successful finish, the popped answer. Errors (overflow, underflow, divide by
// zero) are reported in status and leave the stack untouched. Tokens are handled
// one at a time, an unused code is ignored, and divide runs in the iterative divider
// that retires two quotient bits per cycle over a 48-bit dividend. A new request
// is taken while the previous response still waits in the output register. The
// stack itself is a single-port-write RAM of STACK_DEPTH words and needs no
// clearing after reset.
module postfix_stack_evaluator_core #(
   parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [psev_pkg::OP_W-1:0]          req_operation,
   input  logic signed [psev_pkg::WORD_W-1:0] req_operand,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [psev_pkg::WORD_W-1:0] rsp_top_value,
   output logic [psev_pkg::STATUS_W-1:0]      rsp_status,
   output logic [psev_pkg::LEVEL_W-1:0]       rsp_stack_level,
   output logic                               rsp_answer_valid
);
   import psev_pkg::*;

   ctrl_cmd_type     cmd;
   dpath_status_type st;

   psev_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   psev_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .st               (st),
      .req_operation    (req_operation),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_top_value    (rsp_top_value),
      .rsp_status       (rsp_status),
      .rsp_stack_level  (rsp_stack_level),
      .rsp_answer_valid (rsp_answer_valid)
   );

   // A request in progress blocks further requests until its response is loaded.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
   else $error("request accepted while another is in progress");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_answer_valid |-> rsp_status == ST_OK)
   else $error("answer flagged on an erroneous response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_OVERFLOW |-> rsp_stack_level == LEVEL_W'(STACK_DEPTH))
   else $error("overflow reported on a stack that is not full");

   // Exactly one response per request: a response appears only after an accept.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !req_ready)
   else $error("response loaded with no request in progress");

endmodule

>>> bench/postfix_stack_evaluator_core_tb.sv
module postfix_stack_evaluator_core_tb;
   import psev_pkg::*;

   localparam int CLK_PERIOD = 8;
   localparam int RESET_CYCLES = 10;
   localparam int STACK_SLOTS = STACK_DEPTH_DEF;
   localparam int RANDOM_TOKENS = 1750;
   localparam int QUIET_TOKENS = 250;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int WATCHDOG_CYCLES = 1000000;

   // Codes 6 and 7 have no meaning and must leave the stack alone.
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;
   localparam longint ROUND_HALF = 64'sd32768;
   localparam longint FRAC_SCALE = 64'sd65536;

   typedef struct packed {
      logic signed [WORD_W-1:0] top;
      logic [STATUS_W-1:0]      status;
      logic [LEVEL_W-1:0]       level;
      logic                     answer;
   } token_result_type;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] operand;
      bit                       typed;
      token_result_type         want;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OP_W-1:0]           req_operation = OP_PUSH;
   logic signed [WORD_W-1:0]  req_operand = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [WORD_W-1:0]  rsp_top_value;
   logic [STATUS_W-1:0]       rsp_status;
   logic [LEVEL_W-1:0]        rsp_stack_level;
   logic                      rsp_answer_valid;

   logic signed [WORD_W-1:0]  stack_mem [STACK_SLOTS];
   int                        stack_fill = 0;
   token_result_type          pending_results [$];
   directed_row_type          directed_rows [$];
   token_result_type          observed;
   token_result_type          wanted;
   int                        mismatches = 0;
   int                        tokens_sent = 0;
   bit                        quiet = 1'b0;
   bit                        hold_off_request = 1'b0;

   postfix_stack_evaluator_core #(
      .STACK_DEPTH(STACK_SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_operand(req_operand),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_top_value(rsp_top_value),
      .rsp_status(rsp_status),
      .rsp_stack_level(rsp_stack_level),
      .rsp_answer_valid(rsp_answer_valid)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(WATCHDOG_CYCLES * CLK_PERIOD);
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
      if (v > WORD_MAX) return SAT_MAX;
      if (v < WORD_MIN) return SAT_MIN;
      return v[WORD_W-1:0];
   endfunction

   // Applies one token to the shadow stack and returns the response it should give.
   function automatic token_result_type evaluate_token(input logic [OP_W-1:0] op,
                                                       input logic signed [WORD_W-1:0] operand);
      token_result_type res;
      longint a;
      longint b;
      logic signed [WORD_W-1:0] r;
      bit applied;
      res = '0;
      res.status = ST_OK;
      r = '0;
      applied = 1'b1;
      case (op)
         OP_PUSH: begin
            if (stack_fill >= STACK_SLOTS) begin
               res.status = ST_OVERFLOW;
            end else begin
               stack_mem[stack_fill] = operand;
               stack_fill++;
            end
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (stack_fill < 2) begin
               res.status = ST_UNDERFLOW;
            end else begin
               a = stack_mem[stack_fill - 2];
               b = stack_mem[stack_fill - 1];
               if (op == OP_ADD) begin
                  r = clamp_word(a + b);
               end else if (op == OP_SUB) begin
                  r = clamp_word(a - b);
               end else if (op == OP_MUL) begin
                  r = clamp_word((a * b + ROUND_HALF) >>> 16);
               end else if (b == 0) begin
                  applied = 1'b0;
                  res.status = ST_DIVZERO;
               end else begin
                  r = clamp_word((a * FRAC_SCALE) / b);
               end
               if (applied) begin
                  stack_fill--;
                  stack_mem[stack_fill - 1] = r;
               end
            end
         end
         OP_FINISH: begin
            if (stack_fill == 0) begin
               res.status = ST_UNDERFLOW;
            end else begin
               stack_fill--;
               res.top = stack_mem[stack_fill];
               res.answer = 1'b1;
            end
         end
         default: ;
      endcase
      if (op != OP_FINISH && stack_fill != 0) res.top = stack_mem[stack_fill - 1];
      res.level = LEVEL_W'(stack_fill);
      return res;
   endfunction

   function automatic logic signed [WORD_W-1:0] random_operand();
      int v;
      case ($urandom_range(0, 9))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return '0;
         3: begin
            v = (int'($urandom_range(0, 16)) - 8) * 65536;
            return v;
         end
         4, 5: begin
            v = int'($urandom_range(0, 20'hFFFFF));
            if ($urandom_range(0, 1) == 1) v = -v;
            return v;
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] random_arith_op();
      case ($urandom_range(0, 3))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_MUL;
         default: return OP_DIV;
      endcase
   endfunction

   function automatic void add_row(input logic [OP_W-1:0] op,
                                   input logic signed [WORD_W-1:0] operand,
                                   input bit typed,
                                   input logic signed [WORD_W-1:0] top = '0,
                                   input logic [STATUS_W-1:0] status = ST_OK,
                                   input int level = 0,
                                   input logic answer = 1'b0);
      directed_row_type row;
      row.op = op;
      row.operand = operand;
      row.typed = typed;
      row.want.top = top;
      row.want.status = status;
      row.want.level = LEVEL_W'(level);
      row.want.answer = answer;
      directed_rows.push_back(row);
   endfunction

   // Called in the step of a rising edge; returns in the step of the accepting edge.
   task automatic send_token(input logic [OP_W-1:0] op,
                             input logic signed [WORD_W-1:0] operand,
                             input bit typed = 1'b0,
                             input token_result_type want = '0);
      token_result_type predicted;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_operand <= operand;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = evaluate_token(op, operand);
      pending_results.push_back(typed ? want : predicted);
      if (op <= OP_FINISH) tokens_sent++;
   endtask

   task automatic await_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // A random well-formed expression on top of whatever the stack already holds.
   task automatic send_expression();
      int to_push;
      int live;
      to_push = $urandom_range(1, 6);
      live = 0;
      while (to_push > 0 || live > 1) begin
         if (live >= 2 && (to_push == 0 || $urandom_range(0, 1) == 1)) begin
            send_token(random_arith_op(), $urandom);
            live--;
         end else begin
            send_token(OP_PUSH, random_operand());
            live++;
            to_push--;
         end
      end
      send_token(OP_FINISH, $urandom);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 8)) send_token(OP_W'($urandom_range(0, 7)), random_operand());
   endtask

   task automatic empty_stack();
      while (stack_fill > 0) send_token(OP_FINISH, $urandom);
      send_token(OP_FINISH, $urandom);
   endtask

   // Fills the stack past its top, then reduces it with random operators until empty.
   task automatic fill_and_unwind();
      repeat (STACK_SLOTS - stack_fill + 3) send_token(OP_PUSH, random_operand());
      while (stack_fill > 0) begin
         if ($urandom_range(0, 3) == 0) send_token(OP_FINISH, $urandom);
         else send_token(random_arith_op(), $urandom);
      end
   endtask

   initial begin
      bit filled_once;
      bit filled_twice;
      bit held;
      bit paused;
      int pick;
      filled_once = 1'b0;
      filled_twice = 1'b0;
      held = 1'b0;
      paused = 1'b0;

      add_row(OP_FINISH, $urandom, 1'b1, '0, ST_UNDERFLOW, 0, 1'b0);
      add_row(OP_ADD, $urandom, 1'b1, '0, ST_UNDERFLOW, 0, 1'b0);
      add_row(OP_PUSH, SAT_MAX, 1'b1, SAT_MAX, ST_OK, 1, 1'b0);
      add_row(OP_SUB, $urandom, 1'b1, SAT_MAX, ST_UNDERFLOW, 1, 1'b0);
      add_row(OP_PUSH, SAT_MAX, 1'b1, SAT_MAX, ST_OK, 2, 1'b0);
      add_row(OP_ADD, $urandom, 1'b1, SAT_MAX, ST_OK, 1, 1'b0);
      add_row(OP_PUSH, SAT_MIN, 1'b1, SAT_MIN, ST_OK, 2, 1'b0);
      add_row(OP_MUL, $urandom, 1'b1, SAT_MIN, ST_OK, 1, 1'b0);
      add_row(OP_PUSH, '0, 1'b1, '0, ST_OK, 2, 1'b0);
      add_row(OP_DIV, $urandom, 1'b1, '0, ST_DIVZERO, 2, 1'b0);
      add_row(OP_SPARE_6, $urandom, 1'b1, '0, ST_OK, 2, 1'b0);
      add_row(OP_SPARE_7, $urandom, 1'b1, '0, ST_OK, 2, 1'b0);
      add_row(OP_FINISH, $urandom, 1'b1, '0, ST_OK, 1, 1'b1);
      add_row(OP_PUSH, SAT_MIN, 1'b1, SAT_MIN, ST_OK, 2, 1'b0);
      add_row(OP_SUB, $urandom, 1'b1, '0, ST_OK, 1, 1'b0);
      add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b0);
      add_row(OP_DIV, $urandom, 1'b0);
      add_row(OP_PUSH, 32'h0001_0000, 1'b0);
      add_row(OP_PUSH, 32'hFFFF_8000, 1'b0);
      add_row(OP_MUL, $urandom, 1'b0);
      add_row(OP_PUSH, 32'h0000_0001, 1'b0);
      add_row(OP_DIV, $urandom, 1'b0);
      add_row(OP_FINISH, $urandom, 1'b0);
      add_row(OP_FINISH, $urandom, 1'b0);
      add_row(OP_FINISH, $urandom, 1'b1, '0, ST_UNDERFLOW, 0, 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_token(directed_rows[i].op, directed_rows[i].operand, directed_rows[i].typed,
                    directed_rows[i].want);

      tokens_sent = 0;
      while (tokens_sent < RANDOM_TOKENS) begin
         quiet = (tokens_sent >= RANDOM_TOKENS - QUIET_TOKENS);
         if (!filled_once && tokens_sent >= 300) begin
            filled_once = 1'b1;
            fill_and_unwind();
         end else if (!held && tokens_sent >= 600) begin
            // The receiver stalls for a long stretch while requests keep coming.
            held = 1'b1;
            hold_off_request = 1'b1;
            send_noise();
         end else if (!paused && tokens_sent >= 900) begin
            paused = 1'b1;
            await_idle();
         end else if (!filled_twice && tokens_sent >= 1200) begin
            filled_twice = 1'b1;
            fill_and_unwind();
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) send_expression();
            else if (pick < 92) send_noise();
            else empty_stack();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.top = rsp_top_value;
         observed.status = rsp_status;
         observed.level = rsp_stack_level;
         observed.answer = rsp_answer_valid;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: top=%h status=%0d level=%0d answer=%0b",
                        observed.top, observed.status, observed.level, observed.answer);
         end else begin
            wanted = pending_results.pop_front();
            if (observed.top !== wanted.top || observed.status !== wanted.status ||
                observed.level !== wanted.level || observed.answer !== wanted.answer) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: top=%h/%h status=%0d/%0d level=%0d/%0d answer=%0b/%0b %s",
                           observed.top, wanted.top, observed.status, wanted.status,
                           observed.level, wanted.level, observed.answer, wanted.answer,
                           "(got/expected)");
            end
         end
      end
   end

endmodule
